[rtl/core/rfe_pkg.sv]
// ----------------------------------------------------------------------------
// rfe_pkg - shared types and constants of the reading frame encoder
// beat types, queued job type, byte sequencer steps and framing characters
// ----------------------------------------------------------------------------
package rfe_pkg;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_BAR  = 8'h7C;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;

    typedef struct packed {
        logic [31:0] reading;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_of_item;
        logic       end_of_frame;
    } t_out_beat;

    // one classified reading handed from front to back
    typedef struct packed {
        logic [31:0] reading;
        logic        first;
        logic        last;
    } t_job;

    typedef enum logic [3:0] {
        ST_HASH,
        ST_BAR0,
        ST_D3,
        ST_D2,
        ST_D1,
        ST_D0,
        ST_BAR1,
        ST_CHK,
        ST_BAR2,
        ST_CR,
        ST_LF
    } t_step;

endpackage

[rtl/core/rfe_stream_if.sv]
// ----------------------------------------------------------------------------
// rfe_stream_if - valid/ready stream channel
// one payload beat moves when valid and ready are both high
// ----------------------------------------------------------------------------
interface rfe_stream_if #(
    parameter type t_payload = logic [7:0]
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/rfe_front.sv]
// ----------------------------------------------------------------------------
// rfe_front - input side of the encoder
// accepts readings, tracks the channel position and tags first/last channel
// ----------------------------------------------------------------------------
module rfe_front
    import rfe_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_beat i_beat,
    output logic     o_push_valid,
    input  logic     i_push_ready,
    output t_job     o_push_job
);
    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             is_last;
    logic             accept;

    assign is_last      = (r_idx == LAST_IDX);
    assign o_ready      = i_push_ready;
    assign o_push_valid = i_valid;
    assign accept       = i_valid && i_push_ready;

    always_comb begin
        o_push_job.reading = i_beat.reading;
        o_push_job.first   = (r_idx == '0);
        o_push_job.last    = is_last;
        n_idx              = r_idx;
        if (accept) begin
            n_idx = is_last ? '0 : r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end
endmodule

[rtl/core/rfe_queue.sv]
// ----------------------------------------------------------------------------
// rfe_queue - two-entry job queue
// decouples reading intake from byte emission
// ----------------------------------------------------------------------------
module rfe_queue
    import rfe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_job,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_job
);
    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_job    = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

[rtl/core/rfe_back.sv]
// ----------------------------------------------------------------------------
// rfe_back - byte sequencer of the encoder
// walks each job through its frame bytes, keeps the checksum, drives output
// ----------------------------------------------------------------------------
module rfe_back
    import rfe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    output logic      o_job_ready,
    input  t_job      i_job,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_beat
);
    logic        r_busy;
    t_job        r_job;
    t_step       r_step;
    logic [15:0] r_sum;
    logic        r_out_valid;
    t_out_beat   r_out;

    logic        out_ok;
    logic        adv;
    logic        done;
    logic        pop;
    t_step       end_step;
    logic [7:0]  cur_byte;
    logic        summed;
    logic [7:0]  chk;

    // x mod 255 by folding the two bytes twice
    function automatic logic [7:0] mod255(input logic [15:0] x);
        logic [8:0] s1;
        logic [8:0] s2;
        s1 = {1'b0, x[15:8]} + {1'b0, x[7:0]};
        s2 = {8'd0, s1[8]} + {1'b0, s1[7:0]};
        mod255 = (s2 == 9'd255) ? 8'd0 : s2[7:0];
    endfunction

    assign chk      = mod255(r_sum);
    assign out_ok   = !r_out_valid || i_ready;
    assign adv      = r_busy && out_ok;
    assign end_step = r_job.last ? (r_job.first ? ST_BAR2 : ST_LF) : ST_BAR1;
    assign done     = adv && (r_step == end_step);
    assign o_job_ready = !r_busy || done;
    assign pop      = i_job_valid && o_job_ready;
    assign summed   = (r_step <= ST_BAR1);
    assign o_valid  = r_out_valid;
    assign o_beat   = r_out;

    always_comb begin
        unique case (r_step)
            ST_HASH: cur_byte = CH_HASH;
            ST_D3:   cur_byte = r_job.reading[31:24];
            ST_D2:   cur_byte = r_job.reading[23:16];
            ST_D1:   cur_byte = r_job.reading[15:8];
            ST_D0:   cur_byte = r_job.reading[7:0];
            ST_CHK:  cur_byte = chk;
            ST_CR:   cur_byte = CH_CR;
            ST_LF:   cur_byte = CH_LF;
            ST_BAR0, ST_BAR1, ST_BAR2: cur_byte = CH_BAR;
            default: cur_byte = CH_BAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.frame_byte   <= cur_byte;
            r_out.last_of_item <= (r_step == end_step);
            r_out.end_of_frame <= (r_step == ST_LF);
        end
        if (pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= ST_HASH;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            // sum clears once the frame's final byte is out
            if (done && r_job.last) begin
                r_sum <= '0;
            end else if (adv && summed) begin
                r_sum <= r_sum + {8'd0, cur_byte};
            end

            if (pop) begin
                r_busy <= 1'b1;
                r_step <= i_job.first ? ST_HASH : ST_D3;
            end else if (done) begin
                r_busy <= 1'b0;
            end else if (adv) begin
                r_step <= t_step'(r_step + 4'd1);
            end
        end
    end
endmodule

[rtl/core/reading_frame_encoder_mod255_unit.sv]
// ----------------------------------------------------------------------------
// reading_frame_encoder_mod255_unit - channel readings to checksummed frame
// takes one 32-bit reading per beat and streams out a '#'-framed byte line
// ----------------------------------------------------------------------------
// Each input beat is one channel reading; NUM_CHANNELS readings make a frame.
// Output bytes: '#','|' before the first channel, four reading bytes msb first
// and '|' per channel, then after the last channel the checksum byte, '|', CR
// and LF. The checksum is the sum of all bytes from '#' through the last data
// '|', mod 255, sent raw. While the sink is ready, one output beat leaves per
// cycle; a reading makes 7 bytes for the first channel, 5 for a middle one
// and 9 for the last, set by the back-end sequencer. A two-entry job queue
// sits between intake and sequencer, so readings are taken while bytes of
// earlier ones are still going out and while a finished byte waits for its
// sink. last_of_item marks the last byte of each reading, end_of_frame the LF.
// With a single channel the frame stops after the checksum's '|' (nine bytes)
// and end_of_frame stays low. No clearing pass after reset.
// ----------------------------------------------------------------------------
module reading_frame_encoder_mod255_unit
    import rfe_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rfe_stream_if.sink   i_in,
    rfe_stream_if.source o_out
);
    // front to queue
    logic f_push_valid;
    logic f_push_ready;
    t_job f_push_job;

    // queue to back
    logic q_pop_valid;
    logic q_pop_ready;
    t_job q_pop_job;

    // intake: position in frame and first/last tagging
    rfe_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_beat       (i_in.payload),
        .o_push_valid (f_push_valid),
        .i_push_ready (f_push_ready),
        .o_push_job   (f_push_job)
    );

    // decoupling queue
    rfe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_push_valid),
        .o_push_ready (f_push_ready),
        .i_push_job   (f_push_job),
        .o_pop_valid  (q_pop_valid),
        .i_pop_ready  (q_pop_ready),
        .o_pop_job    (q_pop_job)
    );

    // byte sequencer, checksum and output register
    rfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_pop_valid),
        .o_job_ready (q_pop_ready),
        .i_job       (q_pop_job),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_beat      (o_out.payload)
    );

`ifndef SYNTH
    // frame end only ever on the closing LF
    a_eof_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.end_of_frame)
            |-> (o_out.payload.frame_byte == CH_LF && o_out.payload.last_of_item))
        else $error("end_of_frame on a byte other than the closing LF");

    // every reading's last byte is a separator or the LF
    a_item_end_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.last_of_item)
            |-> (o_out.payload.frame_byte == CH_BAR
                 || o_out.payload.frame_byte == CH_LF))
        else $error("last_of_item on an unexpected byte");

    // a job is only taken by the back end when the queue holds one
    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop_ready && !q_pop_valid) |=> !(o_out.valid && $rose(o_out.valid)
            && o_out.payload.frame_byte == CH_HASH && !$past(o_out.valid)
            && $past(q_pop_ready) && !$past(q_pop_valid) && !$past(o_out.valid)))
        else $error("output started without a queued job");
`endif
endmodule
